>>> src/bitmap_page_frame_allocator_core_defines.svh
// Assertion macros used by the allocator controller.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bpfa_pkg.sv
// Shared constants and controller/datapath interface types for the frame allocator.
package bpfa_pkg;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 16;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic load;
        logic prep;
        logic ptr_inc;
        logic ram_we;
        logic clear_wr;
        logic add_usable;
        logic alloc_set;
        logic free_set;
        logic set_oom;
        logic set_bad;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              usable;
        logic              empty;
        logic              f_oor;
        logic              map_last;
        logic              res_last;
        logic              word_full;
        logic              alloc_found;
        logic              free_bit_set;
        logic              out_free;
    } t_dp_stat;
endpackage

>>> src/bpfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/bpfa_datapath.sv
// Datapath of the frame allocator: map memory, word pointer, counters and result register.
module bpfa_datapath #(
    parameter int NUM_FRAMES = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpfa_pkg::t_dp_cmd             i_cmd,
    output bpfa_pkg::t_dp_stat            o_stat,
    input  logic [bpfa_pkg::MODE_W-1:0]   i_mode,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_base,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_len,
    input  logic                          i_usable,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bpfa_pkg::ADDR_W-1:0]   o_page,
    output logic [bpfa_pkg::STAT_W-1:0]   o_status,
    output logic [bpfa_pkg::CNT_W-1:0]    o_free,
    output logic [bpfa_pkg::CNT_W-1:0]    o_used
);
    localparam int AW    = bpfa_pkg::ADDR_W;
    localparam int WW    = bpfa_pkg::WORD_W;
    localparam int BW    = bpfa_pkg::BIT_W;
    localparam int CNW   = bpfa_pkg::CNT_W;
    localparam int WORDS = (NUM_FRAMES + WW - 1) / WW;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FW    = WAW + BW;
    localparam int NW    = $clog2(NUM_FRAMES + 1);
    localparam int EW    = (NW > FW) ? NW : FW;
    localparam int FBW   = AW - PAGE_SHIFT;
    localparam int UW    = NW;
    localparam int CW    = (UW > CNW) ? UW : CNW;

    logic [bpfa_pkg::MODE_W-1:0] r_mode;
    logic [AW-1:0]               r_base;
    logic [AW-1:0]               r_len;
    logic                        r_usable;
    logic [WAW-1:0]              r_ptr, n_ptr;
    logic [FW-1:0]               r_fs;
    logic [NW-1:0]               r_fe;
    logic                        r_empty;
    logic                        r_oor;
    logic [UW-1:0]               r_ucnt, n_ucnt;
    logic [CNW-1:0]              r_alloc, n_alloc;
    logic [AW-1:0]               r_page;
    logic [bpfa_pkg::STAT_W-1:0] r_status;
    logic                        r_out_valid;
    logic [AW-1:0]               r_o_page;
    logic [bpfa_pkg::STAT_W-1:0] r_o_status;
    logic [CNW-1:0]              r_o_free;
    logic [CNW-1:0]              r_o_used;

    logic [FBW-1:0]  f_full;
    logic [AW:0]     end_sum;
    logic [FBW:0]    fe_raw;
    logic [NW-1:0]   fe_clip;
    logic [WW-1:0]   rdata, wdata, lo_mask, hi_mask, oh, fbit_mask;
    logic [BW-1:0]   enc;
    logic [FW-1:0]   idx;
    logic [EW-1:0]   wb_e, fe_e, fs_e;
    logic            at_fs, at_fe;
    logic [FBW:0]    usum;
    logic [CW-1:0]   ucw, acw, free_diff;
    logic [CNW-1:0]  free_cnt;

    assign f_full  = r_base[AW-1:PAGE_SHIFT];
    assign end_sum = {1'b0, r_base} + {1'b0, r_len};
    assign fe_raw  = end_sum[AW:PAGE_SHIFT];
    assign fe_clip = (fe_raw > (FBW+1)'(NUM_FRAMES)) ? NW'(NUM_FRAMES) : fe_raw[NW-1:0];

    bpfa_ram #(.WIDTH(WW), .DEPTH(WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (r_ptr),
        .i_wdata (wdata),
        .i_raddr (r_ptr),
        .o_rdata (rdata)
    );

    assign wb_e  = EW'({r_ptr, {BW{1'b0}}});
    assign fe_e  = EW'(r_fe);
    assign fs_e  = EW'(r_fs);
    assign at_fs = (wb_e[EW-1:BW] == fs_e[EW-1:BW]);
    assign at_fe = (wb_e[EW-1:BW] == fe_e[EW-1:BW]);

    assign lo_mask   = at_fs ? ({WW{1'b1}} << r_fs[BW-1:0]) : {WW{1'b1}};
    assign hi_mask   = at_fe ? ~({WW{1'b1}} << r_fe[BW-1:0]) : {WW{1'b1}};
    assign oh        = ~rdata & (rdata + WW'(1));
    assign fbit_mask = WW'(1) << r_fs[BW-1:0];

    always_comb begin
        enc = '0;
        for (int j = 0; j < WW; j++) begin
            if (oh[j]) begin
                enc = enc | BW'(j);
            end
        end
    end

    assign idx = {r_ptr, enc};

    always_comb begin
        if (i_cmd.clear_wr) begin
            wdata = '0;
        end else begin
            case (r_mode)
                bpfa_pkg::MODE_ADD:   wdata = rdata | (lo_mask & hi_mask);
                bpfa_pkg::MODE_ALLOC: wdata = rdata | oh;
                default:              wdata = rdata & ~fbit_mask;
            endcase
        end
    end

    assign usum = (FBW+1)'(r_len[AW-1:PAGE_SHIFT]) + (FBW+1)'(r_ucnt);

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.prep) begin
            n_ptr = (r_mode == bpfa_pkg::MODE_ALLOC) ? '0 : f_full[FW-1:BW];
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + WAW'(1);
        end
        n_ucnt = r_ucnt;
        if (i_cmd.add_usable) begin
            n_ucnt = (usum > (FBW+1)'(NUM_FRAMES)) ? UW'(NUM_FRAMES) : usum[UW-1:0];
        end
        n_alloc = r_alloc;
        if (i_cmd.alloc_set && r_alloc != bpfa_pkg::CNT_MAX) begin
            n_alloc = r_alloc + CNW'(1);
        end else if (i_cmd.free_set && r_alloc != '0) begin
            n_alloc = r_alloc - CNW'(1);
        end
    end

    assign ucw       = CW'(r_ucnt);
    assign acw       = CW'(r_alloc);
    assign free_diff = ucw - acw;
    assign free_cnt  = (acw > ucw) ? '0 : free_diff[CNW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_ucnt      <= '0;
            r_alloc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_ucnt      <= n_ucnt;
            r_alloc     <= n_alloc;
            r_out_valid <= i_cmd.out_load | (r_out_valid & ~i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_base   <= i_base;
            r_len    <= i_len;
            r_usable <= i_usable;
        end
        if (i_cmd.prep) begin
            r_fs     <= f_full[FW-1:0];
            r_fe     <= fe_clip;
            r_empty  <= ({1'b0, f_full} >= (FBW+1)'(fe_clip));
            r_oor    <= (f_full >= FBW'(NUM_FRAMES));
            r_page   <= '0;
            r_status <= bpfa_pkg::STAT_OK;
        end else if (i_cmd.set_oom) begin
            r_status <= bpfa_pkg::STAT_OOM;
        end else if (i_cmd.set_bad) begin
            r_status <= bpfa_pkg::STAT_BAD;
        end else if (i_cmd.alloc_set) begin
            r_page   <= AW'(idx) << PAGE_SHIFT;
        end
        if (i_cmd.out_load) begin
            r_o_page   <= r_page;
            r_o_status <= r_status;
            r_o_free   <= free_cnt;
            r_o_used   <= r_alloc;
        end
    end

    assign o_stat.mode         = r_mode;
    assign o_stat.usable       = r_usable;
    assign o_stat.empty        = r_empty;
    assign o_stat.f_oor        = r_oor;
    assign o_stat.map_last     = (r_ptr == WAW'(WORDS - 1));
    assign o_stat.res_last     = (({1'b0, wb_e} + (EW+1)'(WW)) >= {1'b0, fe_e});
    assign o_stat.word_full    = &rdata;
    assign o_stat.alloc_found  = (EW'(idx) < EW'(NUM_FRAMES));
    assign o_stat.free_bit_set = |(rdata & fbit_mask);
    assign o_stat.out_free     = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_page      = r_o_page;
    assign o_status    = r_o_status;
    assign o_free      = r_o_free;
    assign o_used      = r_o_used;
endmodule

>>> src/bpfa_ctrl.sv
// Controller state machine that sequences map clearing, region marking, search and free.
`include "bitmap_page_frame_allocator_core_defines.svh"
module bpfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output bpfa_pkg::t_dp_cmd  o_cmd,
    input  bpfa_pkg::t_dp_stat i_stat
);
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DISP  = 4'd2;
    localparam logic [3:0] ST_ROUTE = 4'd3;
    localparam logic [3:0] ST_R_RD  = 4'd4;
    localparam logic [3:0] ST_R_WR  = 4'd5;
    localparam logic [3:0] ST_A_RD  = 4'd6;
    localparam logic [3:0] ST_A_CHK = 4'd7;
    localparam logic [3:0] ST_F_RD  = 4'd8;
    localparam logic [3:0] ST_F_WR  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.ram_we   = 1'b1;
                o_cmd.clear_wr = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                if (i_stat.map_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_ROUTE;
            end
            ST_ROUTE: begin
                case (i_stat.mode)
                    bpfa_pkg::MODE_ADD: begin
                        if (i_stat.usable) begin
                            o_cmd.add_usable = 1'b1;
                            n_state          = ST_DONE;
                        end else if (i_stat.empty) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_R_RD;
                        end
                    end
                    bpfa_pkg::MODE_ALLOC: n_state = ST_A_RD;
                    bpfa_pkg::MODE_FREE: begin
                        if (i_stat.f_oor) begin
                            o_cmd.set_bad = 1'b1;
                            n_state       = ST_DONE;
                        end else begin
                            n_state = ST_F_RD;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_R_RD: n_state = ST_R_WR;
            ST_R_WR: begin
                o_cmd.ram_we = 1'b1;
                if (i_stat.res_last) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = ST_R_RD;
                end
            end
            ST_A_RD: n_state = ST_A_CHK;
            ST_A_CHK: begin
                if (!i_stat.word_full) begin
                    if (i_stat.alloc_found) begin
                        o_cmd.ram_we    = 1'b1;
                        o_cmd.alloc_set = 1'b1;
                    end else begin
                        o_cmd.set_oom = 1'b1;
                    end
                    n_state = ST_DONE;
                end else if (i_stat.map_last) begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = ST_A_RD;
                end
            end
            ST_F_RD: n_state = ST_F_WR;
            ST_F_WR: begin
                if (i_stat.free_bit_set) begin
                    o_cmd.ram_we   = 1'b1;
                    o_cmd.free_set = 1'b1;
                end else begin
                    o_cmd.set_bad = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `BPFA_ASSERT_IMP(a_we_state, o_cmd.ram_we, (r_state == ST_CLEAR || r_state == ST_R_WR || r_state == ST_A_CHK || r_state == ST_F_WR), "map write outside a write state")
    `BPFA_ASSERT_NXT(a_accept_disp, (i_in_valid && o_in_ready), (r_state == ST_DISP), "accepted item not dispatched")
    `BPFA_ASSERT_IMP(a_out_slot, o_cmd.out_load, i_stat.out_free, "result loaded over a pending result")
    `BPFA_ASSERT_IMP(a_oom_no_write, o_cmd.set_oom, !o_cmd.ram_we, "map written on out of memory")
endmodule

>>> src/bitmap_page_frame_allocator_core.sv
// Top level of the first-fit bitmap page frame allocator.
// Usage: one item per request arrives on the s_axis channel; tuser carries the mode
// (add region, allocate, free) and tdata carries base, length and the usable flag.
// Every item yields exactly one result item on the m_axis channel, with the page
// address, status, free count and used count.
// The used map is held in a RAM of one 64-bit word per 64 frames. After reset the
// block sweeps all (NUM_FRAMES+63)/64 words of that RAM (512 at the default size),
// one word per cycle; s_axis_tready stays low during that sweep.
// A usable region, an empty reserved region, an out-of-range free or an unknown mode
// need no map access; a free reads one map word and clears the frame's bit if it is set,
// a reserved region reads and rewrites each map word it touches, and an allocate reads
// map words in order up to the first word with a clear bit, through the whole map
// when it is full. The map RAM's single read port and the read-modify-write of each
// word set the pace of these steps.
// One item is worked on at a time. A finished result sits in an output register, so
// the next item is accepted while the receiver stalls; a second result waits until
// that register is drained.
module bitmap_page_frame_allocator_core #(
    parameter int NUM_FRAMES = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // base_address, region_length, region_usable, zero pad
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // page_address, free_count, used_count
    output logic [1:0]   m_axis_tuser   // status
);
    bpfa_pkg::t_dp_cmd  cmd;
    bpfa_pkg::t_dp_stat stat;

    logic [bpfa_pkg::ADDR_W-1:0] page;
    logic [bpfa_pkg::CNT_W-1:0]  free_cnt;
    logic [bpfa_pkg::CNT_W-1:0]  used_cnt;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    bpfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (s_axis_tuser),
        .i_base      (s_axis_tdata[47:0]),
        .i_len       (s_axis_tdata[95:48]),
        .i_usable    (s_axis_tdata[96]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_page      (page),
        .o_status    (m_axis_tuser),
        .o_free      (free_cnt),
        .o_used      (used_cnt)
    );

    assign m_axis_tdata = {used_cnt, free_cnt, page};
endmodule
